[hdl/esps_pkg.sv]
// ----------------------------------------------------------------------------
// esps_pkg
// Shared types, constants and helpers for the encoder sub-step estimator.
// ----------------------------------------------------------------------------
package esps_pkg;

    // divider dividend width: slope numerators reach 52 bits plus sign
    localparam int DivNumW = 53;
    localparam int DivCntW = $clog2(DivNumW);
    localparam int MulW    = 33;

    localparam int FineShift  = 20;
    localparam int UsShift    = 16;
    localparam int PrimeOfs   = 32;
    localparam int UsScale    = 62500;

    // configuration register indexes
    localparam logic [1:0] CfgPhaseSplit = 2'd0;
    localparam logic [1:0] CfgIdleLimit  = 2'd1;
    localparam logic [1:0] CfgClkPerUs   = 2'd2;

    localparam logic [8:0] PhaseSplitRst = 9'd128;
    localparam logic [7:0] IdleLimitRst  = 8'd3;
    localparam logic [7:0] ClkPerUsRst   = 8'd125;

    // request to the shared divider
    typedef struct packed {
        logic               start;
        logic [DivNumW-1:0] num;
        logic [31:0]        den;
    } t_div_req;

    // first sub-step of a step: even step at 0, odd step at phase split
    function automatic logic [31:0] step_start(input logic [31:0] step,
                                               input logic [8:0] split);
        logic [31:0] base;
        base = {step[24:1], 8'd0};
        return base + (step[0] ? {23'd0, split} : 32'd0);
    endfunction

    // slope numerator: position delta scaled by 2^20
    function automatic logic [DivNumW-1:0] slope_num(input logic [31:0] dpos);
        return {{(DivNumW-32-FineShift){dpos[31]}}, dpos, {FineShift{1'b0}}};
    endfunction

endpackage

[hdl/esps_div.sv]
// ----------------------------------------------------------------------------
// esps_div
// Iterative signed divider, one quotient bit per cycle, saturating to int32.
// ----------------------------------------------------------------------------
module esps_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esps_pkg::t_div_req  i_req,
    output logic                o_done,
    output logic signed [31:0]  o_quo
);
    import esps_pkg::*;

    logic               r_busy;
    logic [DivCntW-1:0] r_cnt;
    logic [31:0]        r_rem;
    logic [DivNumW-1:0] r_acc;
    logic [31:0]        r_den;
    logic               r_neg;
    logic               r_done;
    logic signed [31:0] r_quo;

    logic [DivNumW-1:0] num_mag;
    logic [31:0]        den_mag;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [31:0]        rem_n;
    logic [DivNumW-1:0] acc_n;
    logic signed [31:0] sat_q;

    // operand magnitudes
    assign num_mag = i_req.num[DivNumW-1] ? (DivNumW'(0) - i_req.num) : i_req.num;
    assign den_mag = i_req.den[31] ? (32'd0 - i_req.den) : i_req.den;

    // one restoring step
    assign rem_sh = {r_rem, r_acc[DivNumW-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign rem_n  = ge ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
    assign acc_n  = {r_acc[DivNumW-2:0], ge};

    // signed result with saturation
    always_comb begin
        if (r_neg) begin
            if (acc_n > DivNumW'(64'h8000_0000)) sat_q = 32'sh8000_0000;
            else sat_q = $signed(32'd0 - acc_n[31:0]);
        end else begin
            if (acc_n > DivNumW'(64'h7FFF_FFFF)) sat_q = 32'sh7FFF_FFFF;
            else sat_q = $signed(acc_n[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == 32'd0) begin
                    // divide by zero saturates by dividend sign
                    r_done <= 1'b1;
                    r_quo  <= i_req.num[DivNumW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= DivCntW'(DivNumW-1);
                    r_rem  <= '0;
                    r_acc  <= num_mag;
                    r_den  <= den_mag;
                    r_neg  <= i_req.num[DivNumW-1] ^ i_req.den[31];
                end
            end else if (r_busy) begin
                r_rem <= rem_n;
                r_acc <= acc_n;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_quo  <= sat_q;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    // checks
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while still busy");

endmodule

[hdl/esps_mul.sv]
// ----------------------------------------------------------------------------
// esps_mul
// Shared registered signed multiplier for the speed and offset products.
// ----------------------------------------------------------------------------
module esps_mul (
    input  logic                                 i_clk,
    input  logic signed [esps_pkg::MulW-1:0]     i_a,
    input  logic signed [esps_pkg::MulW-1:0]     i_b,
    output logic signed [2*esps_pkg::MulW-1:0]   o_p
);
    import esps_pkg::*;

    logic signed [2*MulW-1:0] r_p;

    // product registered before use
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[hdl/encoder_substep_position_speed.sv]
// ----------------------------------------------------------------------------
// encoder_substep_position_speed
// Sub-step position and clamped speed estimate from quadrature step samples.
// ----------------------------------------------------------------------------
// A small sequencer drives one shared divider that yields one quotient bit
// per cycle (up to four divisions per item: transition age, new slope,
// upper and lower bound slopes) and one registered multiplier (two
// products). The first item after reset and items that leave the
// estimator stopped take the short path. The input stalls while an item is
// in work; a finished result waits in the output register until taken.
module encoder_substep_position_speed (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_raw_count,
    input  logic signed [31:0] i_raw_cycles,
    input  logic [31:0]        i_sample_us,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_position,
    output logic signed [31:0] o_speed,
    output logic [31:0]        o_step_count,
    output logic               o_stopped,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data
);
    import esps_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_AGE   = 4'd1;
    localparam logic [3:0] S_UPD   = 4'd2;
    localparam logic [3:0] S_SL1   = 4'd3;
    localparam logic [3:0] S_SHI   = 4'd4;
    localparam logic [3:0] S_SLO   = 4'd5;
    localparam logic [3:0] S_MUL1  = 4'd6;
    localparam logic [3:0] S_MUL1W = 4'd7;
    localparam logic [3:0] S_MUL2  = 4'd8;
    localparam logic [3:0] S_MUL2W = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  r_state;
    logic        r_wait;

    logic [8:0]  r_phase_split;
    logic [7:0]  r_idle_limit;
    logic [7:0]  r_clk_per_us;

    logic [31:0] r_last_step;
    logic [31:0] r_last_sample_time;
    logic [31:0] r_last_trans_time;
    logic [31:0] r_last_trans_pos;
    logic [31:0] r_last_low;
    logic [31:0] r_last_high;
    logic [7:0]  r_idle;
    logic        r_stopped;
    logic signed [31:0] r_speed_fine;
    logic signed [31:0] r_speed_out;
    logic [31:0] r_pos_est;
    logic        r_primed;

    logic [31:0] r_step;
    logic [31:0] r_now;
    logic signed [32:0] r_cycles;
    logic [31:0] r_trans_us;
    logic signed [31:0] r_s_hi;

    logic        r_valid;
    logic [31:0] r_o_position;
    logic signed [31:0] r_o_speed;
    logic [31:0] r_o_step;
    logic        r_o_stopped;

    t_div_req    div_req;
    logic        div_done;
    logic signed [31:0] div_q;
    logic signed [MulW-1:0]   mul_a;
    logic signed [MulW-1:0]   mul_b;
    logic signed [2*MulW-1:0] mul_p;

    logic [31:0] low;
    logic [31:0] high;
    logic [36:0] age_num;
    logic [31:0] dt_prev;
    logic [31:0] since_tr;
    logic        use_prev;
    logic        same;
    logic [7:0]  idle_n;
    logic        stop_now;
    logic        stopped_a;
    logic signed [31:0] fine_hi;
    logic signed [31:0] fine_cl;
    logic [31:0] pos_raw;
    logic        div_state;
    logic        out_free;

    // step bounds of the current sample
    assign low  = step_start(r_step, r_phase_split);
    assign high = step_start(r_step + 32'd1, r_phase_split);

    // loops times 13, done with shifts
    assign age_num = ({{4{r_cycles[32]}}, r_cycles} << 3)
                   + ({{4{r_cycles[32]}}, r_cycles} << 2)
                   + {{4{r_cycles[32]}}, r_cycles};

    // which pair of bounds limits the speed
    assign dt_prev  = r_last_trans_time - r_last_sample_time;
    assign since_tr = r_now - r_last_trans_time;
    assign use_prev = (r_last_trans_time > r_last_sample_time)
                   && ($signed(dt_prev) > $signed(since_tr));

    // idle counter and stop decision
    assign same      = r_step == r_last_step;
    assign idle_n    = !same ? 8'd0 : ((r_idle == 8'hFF) ? r_idle : r_idle + 8'd1);
    assign stop_now  = !r_stopped && (idle_n >= r_idle_limit);
    assign stopped_a = r_stopped | stop_now;

    // clamp between bound slopes
    assign fine_hi = (r_speed_fine > r_s_hi) ? r_s_hi : r_speed_fine;
    assign fine_cl = (fine_hi < div_q) ? div_q : fine_hi;

    assign pos_raw = r_last_trans_pos + mul_p[FineShift+31:FineShift];

    // divider requests
    assign div_state = (r_state == S_AGE) || (r_state == S_SL1)
                    || (r_state == S_SHI) || (r_state == S_SLO);
    always_comb begin
        div_req.start = div_state && !r_wait;
        div_req.num   = '0;
        div_req.den   = 32'd0;
        unique case (r_state)
            S_AGE: begin
                div_req.num = {{(DivNumW-37){age_num[36]}}, age_num};
                div_req.den = {24'd0, r_clk_per_us};
            end
            S_SL1: begin
                div_req.num = slope_num(low - r_last_trans_pos);
                div_req.den = r_trans_us - r_last_trans_time;
            end
            S_SHI: begin
                div_req.num = slope_num(use_prev ? r_last_trans_pos - r_last_low
                                                 : high - r_last_trans_pos);
                div_req.den = use_prev ? dt_prev : since_tr;
            end
            S_SLO: begin
                div_req.num = slope_num(use_prev ? r_last_trans_pos - r_last_high
                                                 : low - r_last_trans_pos);
                div_req.den = use_prev ? dt_prev : since_tr;
            end
            default: begin
                div_req.num = '0;
            end
        endcase
    end

    // multiplier operands
    always_comb begin
        mul_a = {r_speed_fine[31], r_speed_fine};
        if (r_state == S_MUL2) mul_b = {1'b0, r_now - r_trans_us};
        else mul_b = MulW'(UsScale);
    end

    esps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    esps_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign out_free = !r_valid || !i_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_split <= PhaseSplitRst;
            r_idle_limit  <= IdleLimitRst;
            r_clk_per_us  <= ClkPerUsRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgPhaseSplit: r_phase_split <= i_cfg_data;
                CfgIdleLimit:  r_idle_limit  <= i_cfg_data[7:0];
                CfgClkPerUs:   r_clk_per_us  <= i_cfg_data[7:0];
                default:       r_phase_split <= r_phase_split;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_wait             <= 1'b0;
            r_valid            <= 1'b0;
            r_last_step        <= '0;
            r_last_sample_time <= '0;
            r_last_trans_time  <= '0;
            r_last_trans_pos   <= '0;
            r_last_low         <= '0;
            r_last_high        <= '0;
            r_idle             <= '0;
            r_stopped          <= 1'b1;
            r_speed_fine       <= '0;
            r_speed_out        <= '0;
            r_pos_est          <= '0;
            r_primed           <= 1'b0;
        end else begin
            if (r_valid && !i_stall && r_state != S_OUT) r_valid <= 1'b0;
            if (div_req.start) r_wait <= 1'b1;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_step   <= 32'd0 - i_raw_count;
                        r_now    <= i_sample_us;
                        r_cycles <= 33'sd0 - {i_raw_cycles[31], i_raw_cycles};
                        r_state  <= S_AGE;
                    end
                end
                S_AGE: begin
                    if (r_wait && div_done) begin
                        r_wait     <= 1'b0;
                        r_trans_us <= r_now - div_q;
                        if (!r_primed) begin
                            // priming sample
                            r_primed           <= 1'b1;
                            r_last_step        <= r_step;
                            r_last_sample_time <= r_now;
                            r_last_trans_time  <= r_now - div_q;
                            r_pos_est          <= low + 32'(PrimeOfs);
                            r_state            <= S_OUT;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_idle <= idle_n;
                    // stop when idle too long, a new step always restarts
                    r_stopped <= stopped_a && same;
                    if (stop_now) begin
                        r_speed_out  <= '0;
                        r_speed_fine <= '0;
                    end
                    if (!same) begin
                        if (!stopped_a) begin
                            r_state <= S_SL1;
                        end else begin
                            r_last_trans_pos  <= low;
                            r_last_trans_time <= r_trans_us;
                            r_state           <= S_SHI;
                        end
                    end else begin
                        r_state <= stopped_a ? S_FIN : S_SHI;
                    end
                end
                S_SL1: begin
                    if (r_wait && div_done) begin
                        r_wait            <= 1'b0;
                        r_speed_fine      <= div_q;
                        r_stopped         <= 1'b0;
                        r_last_trans_pos  <= low;
                        r_last_trans_time <= r_trans_us;
                        r_state           <= S_SHI;
                    end
                end
                S_SHI: begin
                    if (r_wait && div_done) begin
                        r_wait  <= 1'b0;
                        r_s_hi  <= div_q;
                        r_state <= S_SLO;
                    end
                end
                S_SLO: begin
                    if (r_wait && div_done) begin
                        r_wait       <= 1'b0;
                        r_speed_fine <= fine_cl;
                        r_state      <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL1W;
                S_MUL1W: begin
                    r_speed_out <= $signed(mul_p[UsShift+31:UsShift]);
                    r_state     <= S_MUL2;
                end
                S_MUL2: r_state <= S_MUL2W;
                S_MUL2W: begin
                    // extrapolate and keep within the current step
                    if ($signed(pos_raw - high) > 0) r_pos_est <= high;
                    else if ($signed(pos_raw - low) < 0) r_pos_est <= low;
                    else r_pos_est <= pos_raw;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_last_low         <= low;
                    r_last_high        <= high;
                    r_last_step        <= r_step;
                    r_last_sample_time <= r_now;
                    r_state            <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_valid      <= 1'b1;
                        r_o_position <= r_pos_est;
                        r_o_speed    <= r_speed_out;
                        r_o_step     <= r_step;
                        r_o_stopped  <= r_stopped;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall      = r_state != S_IDLE;
    assign o_valid      = r_valid;
    assign o_position   = r_o_position;
    assign o_speed      = r_o_speed;
    assign o_step_count = r_o_step;
    assign o_stopped    = r_o_stopped;

    // checks
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result shown outside output state");
    a_primed_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_primed |=> r_primed) else $error("primed flag dropped");
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_speed_out == 32'sd0) else $error("speed nonzero while stopped");

endmodule

[sim/encoder_substep_position_speed_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_substep_position_speed_checker
// Watches the sample and result channels, predicts each result from its own
// copy of the estimator state and compares position, speed, step and stop.
// ----------------------------------------------------------------------------
module encoder_substep_position_speed_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [31:0]        i_raw_count,
    input  logic signed [31:0] i_raw_cycles,
    input  logic [31:0]        i_sample_us,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [31:0]        i_position,
    input  logic signed [31:0] i_speed,
    input  logic [31:0]        i_step_count,
    input  logic               i_stopped,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_stops
);
    import esps_pkg::*;

    typedef struct packed {
        logic [31:0]        position;
        logic signed [31:0] speed;
        logic [31:0]        step_count;
        logic               stopped;
    } t_estimate;

    t_estimate estimates_q[$];

    // model copy of configuration and state
    logic [8:0]         split_m;
    logic [7:0]         idle_lim_m;
    logic [7:0]         clk_us_m;
    logic [31:0]        prev_step, prev_sample, trans_time, trans_pos;
    logic [31:0]        low_prev, high_prev, pos_est;
    logic [7:0]         idle_cnt;
    logic               halted, primed_m;
    logic signed [31:0] fine_spd, out_spd;

    assign o_pending = estimates_q.size();

    // saturating signed quotient, zero divisor to the rail
    function automatic logic signed [31:0] quot_sat(input longint num, input longint den);
        longint q;
        if (den == 0) return (num >= 0) ? 32'sh7fffffff : 32'sh80000000;
        q = num / den;
        if (q > 64'sd2147483647) return 32'sh7fffffff;
        if (q < -64'sd2147483648) return 32'sh80000000;
        return q[31:0];
    endfunction

    function automatic logic [31:0] pair_start(input logic [31:0] s);
        return ((s << 7) & 32'hFFFFFF00) + (s[0] ? {23'd0, split_m} : 32'd0);
    endfunction

    function automatic logic signed [31:0] bound_slope(input logic [31:0] dp,
                                                       input logic [31:0] du);
        longint n, d;
        n = longint'($signed(dp)) * (64'sd1 <<< FineShift);
        d = longint'($signed(du));
        return quot_sat(n, d);
    endfunction

    // advance the model by one sample
    function automatic t_estimate predict_sample(input logic [31:0] rc,
                                                 input logic [31:0] cyc,
                                                 input logic [31:0] now);
        t_estimate r;
        logic [31:0] step, tus, lo, hi, dt;
        logic signed [31:0] age, s_hi, s_lo;
        longint off;
        step = 32'd0 - rc;
        age = quot_sat(-longint'($signed(cyc)) * 13, longint'(clk_us_m));
        tus = now - age;
        if (!primed_m) begin
            primed_m = 1'b1;
            prev_step = step;
            prev_sample = now;
            trans_time = tus;
            pos_est = pair_start(step) + PrimeOfs;
        end else begin
            lo = pair_start(step);
            hi = pair_start(step + 1);
            if (step == prev_step) begin
                if (idle_cnt != 8'd255) idle_cnt++;
            end else begin
                idle_cnt = 0;
            end
            if (!halted && idle_cnt >= idle_lim_m) begin
                out_spd = 0;
                fine_spd = 0;
                halted = 1'b1;
            end
            if (step != prev_step) begin
                if (!halted) fine_spd = bound_slope(lo - trans_pos, tus - trans_time);
                halted = 1'b0;
                trans_pos = lo;
                trans_time = tus;
            end
            if (!halted) begin
                dt = trans_time - prev_sample;
                if (trans_time > prev_sample
                    && $signed(dt) > $signed(now - trans_time)) begin
                    s_hi = bound_slope(trans_pos - low_prev, dt);
                    s_lo = bound_slope(trans_pos - high_prev, dt);
                end else begin
                    s_hi = bound_slope(hi - trans_pos, now - trans_time);
                    s_lo = bound_slope(lo - trans_pos, now - trans_time);
                end
                if (fine_spd > s_hi) fine_spd = s_hi;
                if (fine_spd < s_lo) fine_spd = s_lo;
                // arithmetic shifts floor toward minus infinity
                off = (longint'(fine_spd) * 62500) >>> UsShift;
                out_spd = off[31:0];
                off = (longint'(fine_spd) * longint'({32'd0, now - tus})) >>> FineShift;
                pos_est = trans_pos + off[31:0];
                if ($signed(pos_est - hi) > 0) pos_est = hi;
                else if ($signed(pos_est - lo) < 0) pos_est = lo;
            end
            low_prev = lo;
            high_prev = hi;
            prev_step = step;
            prev_sample = now;
        end
        r.position = pos_est;
        r.speed = out_spd;
        r.step_count = step;
        r.stopped = halted;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_estimate e, got;
        if (!i_rst_n) begin
            split_m <= PhaseSplitRst;
            idle_lim_m <= IdleLimitRst;
            clk_us_m <= ClkPerUsRst;
            {prev_step, prev_sample, trans_time, trans_pos} <= '0;
            {low_prev, high_prev, pos_est} <= '0;
            idle_cnt <= '0;
            halted <= 1'b1;
            primed_m <= 1'b0;
            fine_spd <= '0;
            out_spd <= '0;
            o_errors <= 0;
            o_results <= 0;
            o_stops <= 0;
            estimates_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgPhaseSplit: split_m = i_cfg_data;
                    CfgIdleLimit:  idle_lim_m = i_cfg_data[7:0];
                    CfgClkPerUs:   clk_us_m = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                estimates_q.push_back(predict_sample(i_raw_count, i_raw_cycles, i_sample_us));
            // compare an accepted result with the oldest estimate
            if (i_out_valid && !i_out_stall) begin
                got = '{i_position, i_speed, i_step_count, i_stopped};
                o_results <= o_results + 1;
                if (i_stopped) o_stops <= o_stops + 1;
                if (estimates_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", got);
                    o_errors <= o_errors + 1;
                end else begin
                    e = estimates_q.pop_front();
                    if (e !== got) begin
                        if (o_errors < 10)
                            $display({"mismatch exp pos %h spd %0d step %h stop %b,",
                                      " got pos %h spd %0d step %h stop %b"},
                                     e.position, e.speed, e.step_count, e.stopped,
                                     got.position, got.speed, got.step_count, got.stopped);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

[sim/encoder_substep_position_speed_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// encoder_substep_position_speed_test
// Drives step samples and register writes into the sub-step estimator with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module encoder_substep_position_speed_test;
    import esps_pkg::*;

    localparam int IdleLimitCycles = 20000;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, o_valid, i_stall;
    logic [31:0]        i_raw_count, i_sample_us;
    logic signed [31:0] i_raw_cycles;
    logic [31:0]        o_position, o_step_count;
    logic signed [31:0] o_speed;
    logic               o_stopped;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [8:0]         i_cfg_data;
    int                 errors, pending, results, stops;
    int                 quiet_cycles;
    int                 sent;

    // motion track used by well-formed sample sequences
    logic [31:0] pos_steps, clock_us;

    encoder_substep_position_speed DUT (.*);

    encoder_substep_position_speed_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_raw_count(i_raw_count), .i_raw_cycles(i_raw_cycles),
        .i_sample_us(i_sample_us), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_position(o_position), .i_speed(o_speed), .i_step_count(o_step_count),
        .i_stopped(o_stopped), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_stops(stops)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // output stall: random per result, with calm stretches
    initial begin
        int w;
        i_stall = 1'b1;
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (w != 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimitCycles) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // valid stays up after an item unless a gap follows
    task automatic send_sample(input logic [31:0] rc, input logic [31:0] cyc,
                               input logic [31:0] us, input bit allow_gap);
        int w;
        w = 0;
        if (allow_gap && $urandom_range(0, 2) != 0)
            w = $urandom_range(0, 17);
        if (w != 0) begin
            i_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_raw_count <= rc;
        i_raw_cycles <= cyc;
        i_sample_us <= us;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // one sample of plausible motion: steps forward, backward or holding
    task automatic motion_sample();
        int dstep;
        logic [31:0] cyc;
        case ($urandom_range(0, 3))
            0: dstep = 0;
            1: dstep = 1;
            2: dstep = -1;
            default: dstep = $urandom_range(0, 6) - 3;
        endcase
        pos_steps += dstep;
        clock_us += $urandom_range(1, 20000);
        cyc = -$urandom_range(0, 200000);
        send_sample(32'd0 - pos_steps, cyc, clock_us, 1'b1);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CfgPhaseSplit;
        i_cfg_data = '0;
        i_raw_count = '0;
        i_raw_cycles = '0;
        i_sample_us = '0;
        sent = 0;
        quiet_cycles = 0;
        pos_steps = $urandom;
        clock_us = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: priming, extremes of each field, stop and restart
        send_sample(32'd0, 32'd0, 32'd0, 1'b0);
        send_sample(32'hFFFFFFFF, 32'sh80000000, 32'hFFFFFFFF, 1'b0);
        send_sample(32'hFFFFFFFE, 32'd0, 32'd100, 1'b0);
        send_sample(32'hFFFFFFFD, -32'sd1, 32'd5000, 1'b0);
        send_sample(32'hFFFFFFFD, -32'sd500, 32'd9000, 1'b0);
        send_sample(32'hFFFFFFFD, 32'sh80000000, 32'd9001, 1'b0);
        send_sample(32'hFFFFFFFD, -32'sd7, 32'd9002, 1'b0);
        send_sample(32'hFFFFFFFD, -32'sd7, 32'd9003, 1'b0);
        send_sample(32'h80000000, -32'sd100, 32'h7FFFFFFF, 1'b0);
        send_sample(32'h7FFFFFFF, -32'sd100, 32'h80000000, 1'b0);
        send_sample(32'h00000001, 32'sh80000000, 32'h80001000, 1'b0);
        drain();
        // extremes of the registers, zero idle limit stops on every sample that holds its step
        write_reg(CfgPhaseSplit, 9'd256);
        write_reg(CfgIdleLimit, 9'd0);
        write_reg(CfgClkPerUs, 9'd1);
        for (int k = 0; k < 6; k++) motion_sample();
        drain();
        write_reg(CfgPhaseSplit, 9'd0);
        write_reg(CfgIdleLimit, 9'd255);
        write_reg(CfgClkPerUs, 9'd255);
        for (int k = 0; k < 6; k++) motion_sample();
        drain();

        // random phases under varying settings
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CfgPhaseSplit, 9'($urandom_range(0, 256)));
            write_reg(CfgIdleLimit, (ph == 3) ? 9'd1 : 9'($urandom_range(0, 255)));
            write_reg(CfgClkPerUs, 9'($urandom_range(1, 255)));
            if (ph % 3 == 0) write_reg(CfgIdleLimit, 9'($urandom_range(1, 8)));
            for (int k = 0; k < 73; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_sample($urandom, $urandom | 32'h80000000, $urandom,
                                1'b1);
                else if ($urandom_range(0, 19) == 0)
                    send_sample($urandom, 32'd0, clock_us + $urandom, 1'b1);
                else
                    motion_sample();
            end
            drain();
        end

        drain();
        $display("run covered %0d samples, %0d results, %0d of them stopped",
                 sent, results, stops);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
